### rtl/core/sha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// shared types and constants of the sha-256 stream hasher
// ----------------------------------------------------------------------------
package sha_pkg;

  // command passed from the front to the back through the queue
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       eom;
  } cmd_t;

  localparam int unsigned CmdW = 10;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PAD,
    BK_ROUND,
    BK_FOLD,
    BK_OUT
  } bk_state_e;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [6:0] LenPos  = 7'd56;

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0: r = 32'h6A09E667;
      3'd1: r = 32'hBB67AE85;
      3'd2: r = 32'h3C6EF372;
      3'd3: r = 32'hA54FF53A;
      3'd4: r = 32'h510E527F;
      3'd5: r = 32'h9B05688C;
      3'd6: r = 32'h1F83D9AB;
      default: r = 32'h5BE0CD19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] r;
    case (i)
      6'd0: r = 32'h428A2F98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hB5C0FBCF;
      6'd3: r = 32'hE9B5DBA5; 6'd4: r = 32'h3956C25B; 6'd5: r = 32'h59F111F1;
      6'd6: r = 32'h923F82A4; 6'd7: r = 32'hAB1C5ED5; 6'd8: r = 32'hD807AA98;
      6'd9: r = 32'h12835B01; 6'd10: r = 32'h243185BE; 6'd11: r = 32'h550C7DC3;
      6'd12: r = 32'h72BE5D74; 6'd13: r = 32'h80DEB1FE; 6'd14: r = 32'h9BDC06A7;
      6'd15: r = 32'hC19BF174; 6'd16: r = 32'hE49B69C1; 6'd17: r = 32'hEFBE4786;
      6'd18: r = 32'h0FC19DC6; 6'd19: r = 32'h240CA1CC; 6'd20: r = 32'h2DE92C6F;
      6'd21: r = 32'h4A7484AA; 6'd22: r = 32'h5CB0A9DC; 6'd23: r = 32'h76F988DA;
      6'd24: r = 32'h983E5152; 6'd25: r = 32'hA831C66D; 6'd26: r = 32'hB00327C8;
      6'd27: r = 32'hBF597FC7; 6'd28: r = 32'hC6E00BF3; 6'd29: r = 32'hD5A79147;
      6'd30: r = 32'h06CA6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27B70A85;
      6'd33: r = 32'h2E1B2138; 6'd34: r = 32'h4D2C6DFC; 6'd35: r = 32'h53380D13;
      6'd36: r = 32'h650A7354; 6'd37: r = 32'h766A0ABB; 6'd38: r = 32'h81C2C92E;
      6'd39: r = 32'h92722C85; 6'd40: r = 32'hA2BFE8A1; 6'd41: r = 32'hA81A664B;
      6'd42: r = 32'hC24B8B70; 6'd43: r = 32'hC76C51A3; 6'd44: r = 32'hD192E819;
      6'd45: r = 32'hD6990624; 6'd46: r = 32'hF40E3585; 6'd47: r = 32'h106AA070;
      6'd48: r = 32'h19A4C116; 6'd49: r = 32'h1E376C08; 6'd50: r = 32'h2748774C;
      6'd51: r = 32'h34B0BCB5; 6'd52: r = 32'h391C0CB3; 6'd53: r = 32'h4ED8AA4A;
      6'd54: r = 32'h5B9CCA4F; 6'd55: r = 32'h682E6FF3; 6'd56: r = 32'h748F82EE;
      6'd57: r = 32'h78A5636F; 6'd58: r = 32'h84C87814; 6'd59: r = 32'h8CC70208;
      6'd60: r = 32'h90BEFFFA; 6'd61: r = 32'hA4506CEB; 6'd62: r = 32'hBEF9A3F7;
      default: r = 32'hC67178F2;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/sha_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_front
// accepts byte transactions, drops empty ones and queues the rest
// ----------------------------------------------------------------------------
module sha_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sha_pkg::cmd_t       in_cmd_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output sha_pkg::cmd_t       q_cmd_o
);

  // two-entry queue
  sha_pkg::cmd_t mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          push, pop, useful;

  assign useful     = in_cmd_i.present | in_cmd_i.eom;
  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i & in_ready_o & useful;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o & q_ready_i;
  assign q_cmd_o    = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_cmd_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("bad count");
`endif

endmodule

### rtl/core/sha_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_back
// block buffer, padding, one-round-per-cycle compression and digest output
// ----------------------------------------------------------------------------
module sha_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_ready_o,
  input  sha_pkg::cmd_t q_cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [31:0]   out_word_o,
  output logic [2:0]    out_num_o,
  output logic          out_last_o
);

  sha_pkg::bk_state_e state_q, state_d;
  logic [31:0] hw_q [8];
  logic [31:0] w_q [16];
  logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
  logic [63:0] bits_q;
  logic [6:0]  fill_q;
  logic [5:0]  rnd_q;
  logic [2:0]  onum_q;
  logic        pad_q;    // padding pass pending after this block
  logic        final_q;  // this block is the last one of the message
  logic        lenblk_q; // next padding pass writes a zero block with length

  logic take, full_blk;
  logic [31:0] wn, s0, s1, t1, t2, wcur;

  assign q_ready_o   = (state_q == sha_pkg::BK_IDLE);
  assign take        = q_valid_i & q_ready_o;
  assign full_blk    = q_cmd_i.present & (fill_q == 7'd63);
  assign out_valid_o = (state_q == sha_pkg::BK_OUT);
  assign out_word_o  = hw_q[onum_q];
  assign out_num_o   = onum_q;
  assign out_last_o  = (onum_q == 3'd7);

  // schedule and round datapath
  always_comb begin
    s0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
    s1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
         ^ (w_q[14] >> 10);
    wn = w_q[0] + s0 + w_q[9] + s1;
    wcur = w_q[0];
    t1 = h_q + ({e_q[5:0], e_q[31:6]} ^ {e_q[10:0], e_q[31:11]} ^ {e_q[24:0], e_q[31:25]})
         + ((e_q & f_q) ^ (~e_q & g_q)) + sha_pkg::round_k(rnd_q) + wcur;
    t2 = ({a_q[1:0], a_q[31:2]} ^ {a_q[12:0], a_q[31:13]} ^ {a_q[21:0], a_q[31:22]})
         + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sha_pkg::BK_IDLE: begin
        if (take) begin
          if (full_blk) state_d = sha_pkg::BK_ROUND;
          else if (q_cmd_i.eom) state_d = sha_pkg::BK_PAD;
        end
      end
      sha_pkg::BK_PAD:   state_d = sha_pkg::BK_ROUND;
      sha_pkg::BK_ROUND: if (rnd_q == 6'd63) state_d = sha_pkg::BK_FOLD;
      sha_pkg::BK_FOLD: begin
        if (final_q) state_d = sha_pkg::BK_OUT;
        else if (pad_q) state_d = sha_pkg::BK_PAD;
        else state_d = sha_pkg::BK_IDLE;
      end
      sha_pkg::BK_OUT: if (out_ready_i && onum_q == 3'd7) state_d = sha_pkg::BK_IDLE;
      default: state_d = sha_pkg::BK_IDLE;
    endcase
  end

  // byte placement into the schedule store, word i byte j at bits 31-8j
  function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] j,
                                           input logic [7:0] v);
    logic [31:0] r;
    r = w;
    case (j)
      2'd0: r[31:24] = v;
      2'd1: r[23:16] = v;
      2'd2: r[15:8]  = v;
      default: r[7:0] = v;
    endcase
    return r;
  endfunction

  // schedule store and working registers (payload)
  always_ff @(posedge clk_i) begin
    if (take && q_cmd_i.present)
      w_q[fill_q[5:2]] <= put_byte(w_q[fill_q[5:2]], fill_q[1:0], q_cmd_i.data);
    if (state_q == sha_pkg::BK_PAD) begin
      for (int i = 0; i < 16; i++) begin
        if (i >= 14 && (lenblk_q || fill_q < sha_pkg::LenPos)) begin
          w_q[i] <= (i == 14) ? bits_q[63:32] : bits_q[31:0];
        end else if (lenblk_q) begin
          w_q[i] <= 32'd0;
        end else if (i > int'(fill_q[5:2])) begin
          w_q[i] <= 32'd0;
        end else if (i == int'(fill_q[5:2])) begin
          case (fill_q[1:0])
            2'd0: w_q[i] <= {sha_pkg::PadByte, 24'd0};
            2'd1: w_q[i] <= {w_q[i][31:24], sha_pkg::PadByte, 16'd0};
            2'd2: w_q[i] <= {w_q[i][31:16], sha_pkg::PadByte, 8'd0};
            default: w_q[i] <= {w_q[i][31:8], sha_pkg::PadByte};
          endcase
        end
      end
    end
    if (state_q == sha_pkg::BK_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wn;
    end
    if (state_q == sha_pkg::BK_ROUND) begin
      h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
      d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
    end else begin
      a_q <= hw_q[0]; b_q <= hw_q[1]; c_q <= hw_q[2]; d_q <= hw_q[3];
      e_q <= hw_q[4]; f_q <= hw_q[5]; g_q <= hw_q[6]; h_q <= hw_q[7];
    end
  end

  // control state, hash words and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sha_pkg::BK_IDLE;
      bits_q   <= 64'd0;
      fill_q   <= 7'd0;
      rnd_q    <= 6'd0;
      onum_q   <= 3'd0;
      pad_q    <= 1'b0;
      final_q  <= 1'b0;
      lenblk_q <= 1'b0;
      for (int i = 0; i < 8; i++) hw_q[i] <= sha_pkg::init_h(3'(i));
    end else begin
      state_q <= state_d;
      if (take) begin
        if (q_cmd_i.present) begin
          bits_q <= bits_q + 64'd8;
          fill_q <= full_blk ? 7'd0 : fill_q + 7'd1;
        end
        pad_q   <= q_cmd_i.eom;
        final_q <= 1'b0;
      end
      if (state_q == sha_pkg::BK_PAD) begin
        final_q  <= lenblk_q || fill_q < sha_pkg::LenPos;
        lenblk_q <= !lenblk_q && fill_q >= sha_pkg::LenPos;
        pad_q    <= !lenblk_q && fill_q >= sha_pkg::LenPos;
      end
      if (state_q == sha_pkg::BK_ROUND) rnd_q <= rnd_q + 6'd1;
      if (state_q == sha_pkg::BK_FOLD) begin
        hw_q[0] <= hw_q[0] + a_q; hw_q[1] <= hw_q[1] + b_q;
        hw_q[2] <= hw_q[2] + c_q; hw_q[3] <= hw_q[3] + d_q;
        hw_q[4] <= hw_q[4] + e_q; hw_q[5] <= hw_q[5] + f_q;
        hw_q[6] <= hw_q[6] + g_q; hw_q[7] <= hw_q[7] + h_q;
      end
      if (state_q == sha_pkg::BK_OUT && out_ready_i) begin
        onum_q <= onum_q + 3'd1;
        if (onum_q == 3'd7) begin
          bits_q   <= 64'd0;
          fill_q   <= 7'd0;
          pad_q    <= 1'b0;
          final_q  <= 1'b0;
          lenblk_q <= 1'b0;
          for (int i = 0; i < 8; i++) hw_q[i] <= sha_pkg::init_h(3'(i));
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_rnd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != sha_pkg::BK_ROUND) |-> (rnd_q == 6'd0)) else $error("round count");
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < 7'd64) else $error("fill range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(onum_q)))
    else $error("output dropped");
`endif

endmodule

### rtl/core/sha256_stream_hasher_top.sv
`timescale 1ns / 1ps
// flow: the back end stores bytes into the block buffer while idle; a full block
// then runs 64 rounds and a fold, and no new bytes are taken until that is done
// an end transaction adds a padding pass (one or two blocks) then 8 output words
// reset: asynchronous active-low, restores initial hash values and clears counts
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// sha-256 over a byte stream, front queue feeding the compression back end
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // byte_present
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_number[34:32], zero pad
  output logic        m_axis_tlast    // last_word
);

  sha_pkg::cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;
  logic [31:0] word;
  logic [2:0]  num;

  assign in_cmd.data    = s_axis_tdata;
  assign in_cmd.present = s_axis_tuser;
  assign in_cmd.eom     = s_axis_tlast;

  sha_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_cmd_i(in_cmd),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  sha_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cmd_i(q_cmd),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_word_o(word), .out_num_o(num), .out_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, num, word};

endmodule
